FILE: sv/dpr_pkg.sv
// ----------------------------------------------------------------------------
// dpr_pkg
// Shared types, codes and helpers for the debug packet receiver.
// ----------------------------------------------------------------------------
package dpr_pkg;

    // default payload limit of one packet
    localparam int DEF_MAX_PAYLOAD = 511;

    // results one received byte can cause, and queue depth between front and back
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 4;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_SEND    = 2'd1;
    localparam logic [1:0] KIND_ACCEPT  = 2'd2;
    localparam logic [1:0] KIND_DISCARD = 2'd3;

    // framing characters
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;

    // one result transaction without the last flag
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } result_t;

    // all results caused by one received byte
    typedef struct packed {
        logic [RES_CNT_W-1:0]         count;
        result_t [MAX_RESULTS-1:0]    res;
    } cmd_t;

    // hex digit value, all ones for a bad digit
    function automatic logic [7:0] hexval(logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h61 + 8'd10;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h41 + 8'd10;
        end
        else
        begin
            v = 8'hFF;
        end
        return v;
    endfunction

endpackage

FILE: sv/dpr_if.sv
// ----------------------------------------------------------------------------
// dpr_if
// Valid/ready channels of the debug packet receiver: received bytes and results.
// ----------------------------------------------------------------------------

// received byte channel
interface dpr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface dpr_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output kind, output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

FILE: sv/dpr_front.sv
// ----------------------------------------------------------------------------
// dpr_front
// Packet parser: takes one byte per transaction, tracks framing, checksum and
// held bytes, and builds the list of results that byte causes.
// ----------------------------------------------------------------------------
module dpr_front #(
    parameter int MAX_PAYLOAD = dpr_pkg::DEF_MAX_PAYLOAD
) (
    input  logic          clk,
    input  logic          rst_n,
    dpr_rx_if.sink        rx,
    input  logic          q_full,
    output logic          push,
    output dpr_pkg::cmd_t cmd
);
    import dpr_pkg::*;

    localparam int               CNT_W  = $clog2(MAX_PAYLOAD);
    localparam logic [CNT_W-1:0] LIMIT  = CNT_W'(MAX_PAYLOAD - 1);
    localparam logic [CNT_W-1:0] HOLD_N = CNT_W'(3);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;
    localparam logic [1:0] PH_LO   = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [7:0]       sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       held_reg [3];
    logic [7:0]       held_next [3];
    logic [7:0]       sum_high_reg, sum_high_next;
    logic             seq_reg, seq_next;

    logic             accept;
    logic [7:0]       b;
    logic [7:0]       hv;
    logic [7:0]       got;
    logic [CNT_W-1:0] cnt_inc;
    cmd_t             c;

    // append one result to the list
    function automatic cmd_t add_res(cmd_t cin, logic [1:0] k, logic [7:0] d);
        cmd_t co;
        co = cin;
        co.res[co.count[RES_IDX_W-1:0]] = '{kind: k, data: d};
        co.count = co.count + 1'b1;
        return co;
    endfunction

    assign accept   = rx.valid && rx.ready;
    assign rx.ready = !q_full;
    assign b        = rx.rx_byte;
    assign hv       = hexval(b);
    assign got      = sum_high_reg + hv;
    assign cnt_inc  = count_reg + 1'b1;

    // next state and result list for the incoming byte
    always_comb
    begin
        phase_next    = phase_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        held_next     = held_reg;
        sum_high_next = sum_high_reg;
        seq_next      = seq_reg;
        c             = '0;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (b == CHAR_DOLLAR)
                begin
                    sum_next   = '0;
                    count_next = '0;
                    seq_next   = 1'b0;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (b == CHAR_DOLLAR)
                begin
                    // restart inside the body
                    c          = add_res(c, KIND_DISCARD, 8'h00);
                    sum_next   = '0;
                    count_next = '0;
                    seq_next   = 1'b0;
                end
                else if (b == CHAR_HASH)
                begin
                    // short packet releases only what was written
                    for (int i = 0; i < 3; i++)
                    begin
                        if (count_reg < HOLD_N && count_reg > CNT_W'(i))
                        begin
                            c = add_res(c, KIND_PAYLOAD, held_reg[i]);
                        end
                    end
                    phase_next = PH_HI;
                end
                else
                begin
                    sum_next   = sum_reg + b;
                    count_next = cnt_inc;
                    if (count_reg < HOLD_N)
                    begin
                        held_next[count_reg[1:0]] = b;
                    end
                    if (cnt_inc == HOLD_N)
                    begin
                        if (b == CHAR_COLON)
                        begin
                            seq_next = 1'b1;
                        end
                        else
                        begin
                            c = add_res(c, KIND_PAYLOAD, held_reg[0]);
                            c = add_res(c, KIND_PAYLOAD, held_reg[1]);
                            c = add_res(c, KIND_PAYLOAD, b);
                        end
                    end
                    else if (cnt_inc > HOLD_N)
                    begin
                        c = add_res(c, KIND_PAYLOAD, b);
                    end
                    // payload limit drops the packet
                    if (cnt_inc >= LIMIT)
                    begin
                        c          = add_res(c, KIND_DISCARD, 8'h00);
                        phase_next = PH_HUNT;
                    end
                end
            end
            PH_HI:
            begin
                sum_high_next = {hv[3:0], 4'h0};
                phase_next    = PH_LO;
            end
            PH_LO:
            begin
                if (got == sum_reg)
                begin
                    c = add_res(c, KIND_SEND, CHAR_PLUS);
                    if (seq_reg)
                    begin
                        c = add_res(c, KIND_SEND, held_reg[0]);
                        c = add_res(c, KIND_SEND, held_reg[1]);
                    end
                    c = add_res(c, KIND_ACCEPT, 8'h00);
                end
                else
                begin
                    c = add_res(c, KIND_SEND, CHAR_MINUS);
                    c = add_res(c, KIND_DISCARD, 8'h00);
                end
                phase_next = PH_HUNT;
            end
        endcase
    end

    assign cmd  = c;
    assign push = accept && (c.count != '0);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            sum_reg      <= '0;
            count_reg    <= '0;
            sum_high_reg <= '0;
            seq_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            sum_high_reg <= sum_high_next;
            seq_reg      <= seq_next;
        end
    end

    // held payload bytes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

    // a byte seen while hunting never produces results
    a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_HUNT) |-> !push)
        else $error("result produced while hunting");

endmodule

FILE: sv/dpr_queue.sv
// ----------------------------------------------------------------------------
// dpr_queue
// Short queue of result lists between parser and result sequencer.
// ----------------------------------------------------------------------------
module dpr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dpr_pkg::cmd_t wr_cmd,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output dpr_pkg::cmd_t head
);
    import dpr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;

    assign full  = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue read while empty");

endmodule

FILE: sv/dpr_back.sv
// ----------------------------------------------------------------------------
// dpr_back
// Result sequencer: walks the queue head list, one result per cycle unless
// stalled, into a registered output stage; marks the final one as last.
// ----------------------------------------------------------------------------
module dpr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  dpr_pkg::cmd_t head,
    output logic          pop,
    dpr_res_if.source     res
);
    import dpr_pkg::*;

    logic [RES_IDX_W-1:0] idx_reg;
    logic                 out_valid_reg;
    logic [1:0]           out_kind_reg;
    logic [7:0]           out_data_reg;
    logic                 out_last_reg;

    logic                 load;
    logic                 last_item;
    result_t              cur;

    assign load      = !empty && (!out_valid_reg || res.ready);
    assign last_item = ({1'b0, idx_reg} + 1'b1) == head.count;
    assign cur       = head.res[idx_reg];
    assign pop       = load && last_item;

    assign res.valid     = out_valid_reg;
    assign res.kind      = out_kind_reg;
    assign res.data_byte = out_data_reg;
    assign res.last      = out_last_reg;

    // position within the head list and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= last_item ? '0 : idx_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg <= cur.kind;
            out_data_reg <= cur.data;
            out_last_reg <= last_item;
        end
    end

    a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ({1'b0, idx_reg} < head.count))
        else $error("sequencer index beyond list");

    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_ACCEPT) |-> out_last_reg)
        else $error("accept marker not last");

endmodule

FILE: sv/debug_packet_receiver.sv
// ----------------------------------------------------------------------------
// debug_packet_receiver
// Receive side of a remote-debug serial packet link: framing, checksum check,
// sequence id handling and payload release.
//
//   channel  dir  handshake     payload
//   rx       in   valid/ready   rx_byte[7:0]
//   res      out  valid/ready   kind[1:0], data_byte[7:0], last
//
// A byte is taken every cycle while the four-entry queue has room.
// Results leave one per cycle from a registered output stage while res is
// ready; a byte causes up to four results; the output stage sets the rate.
// Reset is asynchronous, active low; it returns the parser to hunting for '$'.
// A stalled result side fills the queue and then holds rx ready low.
// ----------------------------------------------------------------------------
module debug_packet_receiver #(
    parameter int MAX_PAYLOAD = dpr_pkg::DEF_MAX_PAYLOAD
) (
    input  logic      clk,
    input  logic      rst_n,
    dpr_rx_if.sink    rx,
    dpr_res_if.source res
);
    import dpr_pkg::*;

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    cmd_t wr_cmd;
    cmd_t head;

    // parser
    dpr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .q_full (q_full),
        .push   (push),
        .cmd    (wr_cmd)
    );

    // result list queue
    dpr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .full   (q_full),
        .empty  (q_empty),
        .head   (head)
    );

    // result sequencer
    dpr_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (q_empty),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the debug packet receiver. A byte stream of framed packets,
// noise, restarts and broken checksums is driven into the rx channel, and every
// result on the res channel is checked against a packet parser model kept in
// a small scoreboard, with two mixes of sender and receiver stalls, then none.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dpr_pkg::*;

    localparam int PAYLOAD_LIMIT  = DEF_MAX_PAYLOAD;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;

    typedef enum logic [1:0] {
        PARSE_HUNT,
        PARSE_BODY,
        PARSE_SUM_HI,
        PARSE_SUM_LO
    } parse_phase_t;

    typedef enum int {
        CK_GOOD,
        CK_WRONG,
        CK_BAD_DIGIT
    } checksum_mode_t;

    // packet parser model and store of expected result transactions
    class pkt_scoreboard;
        typedef struct {
            logic [1:0] kind;
            logic [7:0] data;
            logic       last;
        } result_rec_t;

        parse_phase_t phase;
        logic [7:0]   run_sum;
        int unsigned  pay_count;
        logic [7:0]   held [3];
        logic [7:0]   sum_hi;
        bit           seq_id;
        int           limit;

        result_rec_t  expected_q [$];
        result_rec_t  step_q [$];

        int unsigned  errors;
        int unsigned  checked;
        int unsigned  n_accepted;
        int unsigned  n_discarded;

        function new(int max_payload);
            limit       = max_payload;
            phase       = PARSE_HUNT;
            run_sum     = '0;
            pay_count   = 0;
            held        = '{default: '0};
            sum_hi      = '0;
            seq_id      = 1'b0;
            errors      = 0;
            checked     = 0;
            n_accepted  = 0;
            n_discarded = 0;
        endfunction

        // hex digit value, all ones when the byte is no hex digit
        static function logic [7:0] digit_value(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39)
            begin
                return c - 8'h30;
            end
            if (c >= 8'h61 && c <= 8'h66)
            begin
                return c - 8'h57;
            end
            if (c >= 8'h41 && c <= 8'h46)
            begin
                return c - 8'h37;
            end
            return 8'hFF;
        endfunction

        function void start_packet();
            run_sum   = '0;
            pay_count = 0;
            seq_id    = 1'b0;
        endfunction

        function void add(logic [1:0] kind, logic [7:0] data);
            result_rec_t r;
            r.kind = kind;
            r.data = data;
            r.last = 1'b0;
            step_q.push_back(r);
        endfunction

        // advance the parser by one accepted byte and queue what it causes
        function void note_rx_byte(logic [7:0] b);
            logic [7:0] dv;
            logic [7:0] got;
            step_q.delete();
            case (phase)
                PARSE_HUNT:
                begin
                    if (b == CHAR_DOLLAR)
                    begin
                        start_packet();
                        phase = PARSE_BODY;
                    end
                end
                PARSE_BODY:
                begin
                    if (b == CHAR_DOLLAR)
                    begin
                        add(KIND_DISCARD, 8'h00);
                        start_packet();
                    end
                    else if (b == CHAR_HASH)
                    begin
                        // short packet: held bytes go out on the end mark
                        if (pay_count < 3)
                        begin
                            for (int i = 0; i < pay_count; i++)
                            begin
                                add(KIND_PAYLOAD, held[i]);
                            end
                        end
                        phase = PARSE_SUM_HI;
                    end
                    else
                    begin
                        run_sum = run_sum + b;
                        if (pay_count < 3)
                        begin
                            held[pay_count] = b;
                        end
                        pay_count++;
                        if (pay_count == 3)
                        begin
                            if (held[2] == CHAR_COLON)
                            begin
                                seq_id = 1'b1;
                            end
                            else
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    add(KIND_PAYLOAD, held[i]);
                                end
                            end
                        end
                        else if (pay_count > 3)
                        begin
                            add(KIND_PAYLOAD, b);
                        end
                        // payload limit drops the packet
                        if (pay_count >= limit - 1)
                        begin
                            add(KIND_DISCARD, 8'h00);
                            phase = PARSE_HUNT;
                        end
                    end
                end
                PARSE_SUM_HI:
                begin
                    dv     = digit_value(b);
                    sum_hi = {dv[3:0], 4'h0};
                    phase  = PARSE_SUM_LO;
                end
                default:
                begin
                    got = sum_hi + digit_value(b);
                    if (got == run_sum)
                    begin
                        add(KIND_SEND, CHAR_PLUS);
                        if (seq_id)
                        begin
                            add(KIND_SEND, held[0]);
                            add(KIND_SEND, held[1]);
                        end
                        add(KIND_ACCEPT, 8'h00);
                    end
                    else
                    begin
                        add(KIND_SEND, CHAR_MINUS);
                        add(KIND_DISCARD, 8'h00);
                    end
                    phase = PARSE_HUNT;
                end
            endcase
            if (step_q.size() > 0)
            begin
                step_q[step_q.size() - 1].last = 1'b1;
            end
            foreach (step_q[i])
            begin
                expected_q.push_back(step_q[i]);
            end
        endfunction

        // compare one result transaction with the oldest expectation
        function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
            result_rec_t e;
            checked++;
            if (kind == KIND_ACCEPT)
            begin
                n_accepted++;
            end
            if (kind == KIND_DISCARD)
            begin
                n_discarded++;
            end
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: kind %0d data_byte 0x%02h last %0b",
                       kind, data, last);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (kind !== e.kind)
            begin
                $error("kind: expected %0d, actual %0d", e.kind, kind);
                errors++;
            end
            if (data !== e.data)
            begin
                $error("data_byte: expected 0x%02h, actual 0x%02h", e.data, data);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last: expected %0b, actual %0b", e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dpr_rx_if  rx_ch ();
    dpr_res_if res_ch ();

    debug_packet_receiver #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    pkt_scoreboard sb;
    logic [7:0]    stim_q [$];
    int            src_idle_pct;
    int            sink_idle_pct;
    int unsigned   bytes_sent;
    int unsigned   stall_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            sb.check_result(res_ch.kind, res_ch.data_byte, res_ch.last);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no transaction for %0d cycles", stall_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
        if (nib < 4'd10)
        begin
            return 8'h30 + nib;
        end
        return (upper ? 8'h37 : 8'h57) + nib;
    endfunction

    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(255));
        end
        while (b == CHAR_DOLLAR || b == CHAR_HASH);
        return b;
    endfunction

    function automatic logic [7:0] bad_digit();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(255));
        end
        while (pkt_scoreboard::digit_value(b) != 8'hFF);
        return b;
    endfunction

    // frame a body as '$' body '#' and two checksum digits
    task automatic add_packet(input logic [7:0] body [$], input checksum_mode_t mode);
        logic [7:0] sum;
        logic [7:0] hi_c;
        logic [7:0] lo_c;
        sum = '0;
        stim_q.push_back(CHAR_DOLLAR);
        foreach (body[i])
        begin
            sum = sum + body[i];
            stim_q.push_back(body[i]);
        end
        stim_q.push_back(CHAR_HASH);
        if (mode == CK_WRONG)
        begin
            sum = sum + 8'($urandom_range(1, 255));
        end
        hi_c = hex_char(sum[7:4], 1'($urandom_range(1)));
        lo_c = hex_char(sum[3:0], 1'($urandom_range(1)));
        if (mode == CK_BAD_DIGIT)
        begin
            if ($urandom_range(1))
            begin
                hi_c = bad_digit();
            end
            else
            begin
                lo_c = bad_digit();
            end
        end
        stim_q.push_back(hi_c);
        stim_q.push_back(lo_c);
    endtask

    task automatic add_random_packet(input int len);
        logic [7:0]     body [$];
        bit             with_seq;
        int             pick;
        checksum_mode_t mode;
        with_seq = (len >= 3) && ($urandom_range(99) < 35);
        for (int i = 0; i < len; i++)
        begin
            body.push_back((with_seq && i == 2) ? CHAR_COLON : payload_byte());
        end
        pick = $urandom_range(99);
        mode = (pick < 80) ? CK_GOOD : ((pick < 90) ? CK_WRONG : CK_BAD_DIGIT);
        add_packet(body, mode);
    endtask

    function automatic int packet_len();
        return ($urandom_range(99) < 80) ? $urandom_range(0, 6) : $urandom_range(7, 20);
    endfunction

    // mostly framed packets, some noise, restarts and cut-off checksums
    task automatic add_random_traffic(input int n);
        int start;
        int pick;
        start = stim_q.size();
        while (stim_q.size() - start < n)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                add_random_packet(packet_len());
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    stim_q.push_back(8'($urandom_range(255)));
                end
            end
            else if (pick < 90)
            begin
                stim_q.push_back(CHAR_DOLLAR);
                repeat ($urandom_range(0, 4))
                begin
                    stim_q.push_back(payload_byte());
                end
                add_random_packet(packet_len());
            end
            else
            begin
                stim_q.push_back(CHAR_DOLLAR);
                repeat ($urandom_range(0, 5))
                begin
                    stim_q.push_back(payload_byte());
                end
                stim_q.push_back(CHAR_HASH);
                stim_q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            end
        end
    endtask

    task automatic add_directed();
        logic [7:0] body [$];
        // noise while hunting, extremes of the byte
        stim_q.push_back(8'h00);
        stim_q.push_back(8'hFF);
        stim_q.push_back(CHAR_HASH);
        stim_q.push_back(CHAR_PLUS);
        // empty packet
        add_packet(body, CK_GOOD);
        // sequence id "a0" and one payload byte
        body = '{8'h61, 8'h30, CHAR_COLON, 8'h00};
        add_packet(body, CK_GOOD);
        // restart in body, then '$' and '#' taken as checksum digits
        stim_q.push_back(CHAR_DOLLAR);
        stim_q.push_back(8'hFF);
        stim_q.push_back(CHAR_DOLLAR);
        stim_q.push_back(8'h41);
        stim_q.push_back(CHAR_HASH);
        stim_q.push_back(CHAR_DOLLAR);
        stim_q.push_back(CHAR_HASH);
        // short packet rejected
        body = '{8'h80, 8'h7F};
        add_packet(body, CK_WRONG);
        // three bytes with a bad checksum digit
        body = '{8'h01, 8'h3A, 8'h02};
        add_packet(body, CK_BAD_DIGIT);
    endtask

    // one rx transaction; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < src_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < src_idle_pct)
            begin
                @(negedge clk);
            end
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_rx_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic drive_queued();
        foreach (stim_q[i])
        begin
            send_byte(stim_q[i]);
        end
        stim_q.delete();
        rx_ch.valid <= 1'b0;
    endtask

    // sender holds off until every expected result has come
    task automatic wait_drained();
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    // main sequence
    initial
    begin
        sb            = new(PAYLOAD_LIMIT);
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        res_ch.ready  = 1'b0;
        bytes_sent    = 0;
        stall_cycles  = 0;
        src_idle_pct  = 11;
        sink_idle_pct = 73;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sender mostly busy, receiver mostly stalled
        add_directed();
        add_random_traffic(48);
        drive_queued();
        wait_drained();

        // sender mostly idle, receiver mostly ready
        src_idle_pct  = 73;
        sink_idle_pct = 11;
        add_random_traffic(48);
        drive_queued();
        wait_drained();

        // no stalls on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        add_random_traffic(48);
        drive_queued();

        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d rx bytes and %0d results: %0d packets accepted, %0d discarded,",
                 bytes_sent, sb.checked, sb.n_accepted, sb.n_discarded);
        $display("with framing noise, restarts, bad digits and short packets");
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/dpr_pkg.sv
sv/dpr_if.sv
sv/dpr_front.sv
sv/dpr_queue.sv
sv/dpr_back.sv
sv/debug_packet_receiver.sv
dv/tb_top.sv
